// File: rtl/smcke_pkg.sv
package smcke_pkg;

  localparam int NUM_DESC            = 4;
  localparam int MAX_PARTS           = 4;
  localparam int MAX_BUFFERED_BYTES  = 8;
  localparam int BLOB_LENGTH_BYTES   = 2;
  localparam int PART_SIZE_BITS      = 12;
  localparam int DESC_BITS           = 17;
  localparam int CFG_INDEX_BITS      = 3;
  localparam int PART_INDEX_BITS     = 3;
  localparam int DESC_SEL_BITS       = $clog2(NUM_DESC);
  localparam int BYTE_IN_PART_BITS   = PART_SIZE_BITS + 1;
  localparam int LENGTH_BITS         = 15;
  localparam int STATUS_BITS         = 2;
  localparam int LANE_BITS           = $clog2(MAX_BUFFERED_BYTES);
  localparam int COUNT_BITS          = $clog2(MAX_BUFFERED_BYTES + 1);
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       key_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   run_last;
    logic                   key_done;
    logic [LENGTH_BITS-1:0] encoded_length;
    logic [STATUS_BITS-1:0] status;
  } result_t;

  // At most one command per input beat: up to eight bytes read out from lane
  // start downward, then an optional closing beat.
  typedef struct packed {
    logic [MAX_BUFFERED_BYTES-1:0][7:0] lanes;
    logic [LANE_BITS-1:0]               start;
    logic [COUNT_BITS-1:0]              count;
    logic                               invert;
    logic                               flip_first;
    logic                               done;
    logic [LENGTH_BITS-1:0]             length;
    logic [STATUS_BITS-1:0]             status;
  } cmd_t;

endpackage

// File: rtl/sortable_multi_column_key_encoder.sv
// Order-preserving key encoder: source key bytes are pushed one beat per
// cycle, with key_end on the last; results pop out one beat per cycle, each
// an encoded byte or the closing beat with encoded_length and status. The
// front takes a beat every cycle as long as its command queue (QUEUE_DEPTH
// entries) has room; the back drains one result per cycle, so a beat that
// completes an 8-byte number yields eight results plus one for the close,
// and a sustained input rate of one beat per cycle holds when results per
// beat average one. The user must configure parts through cfg_* only while
// the block is idle; the block does not enforce this. Writes are always
// ready. No clearing pass after reset.
module sortable_multi_column_key_encoder #(
  parameter int QUEUE_DEPTH = smcke_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smcke_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [smcke_pkg::DESC_BITS-1:0]      cfg_data,
  input  logic                                 push,
  output logic                                 full,
  input  smcke_pkg::in_item_t                  item,
  output logic                                 empty,
  input  logic                                 pop,
  output smcke_pkg::result_t                   result
);
  import smcke_pkg::*;

  cmd_t q_in, q_out;
  logic q_push, q_pop, q_full, q_empty;

  assign full = q_full;

  smcke_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (q_full),
    .item      (item),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  smcke_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  smcke_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_out),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// File: rtl/smcke_front.sv
module smcke_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smcke_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [smcke_pkg::DESC_BITS-1:0]      cfg_data,
  input  logic                                push,
  input  logic                                full,
  input  smcke_pkg::in_item_t                 item,
  output logic                                q_push,
  output smcke_pkg::cmd_t                     q_cmd
);
  import smcke_pkg::*;

  localparam logic [2:0] T_LONGLONG = 3'd1;
  localparam logic [2:0] T_NUMBER   = 3'd2;
  localparam logic [2:0] T_FLOAT    = 3'd3;
  localparam logic [2:0] T_DOUBLE   = 3'd4;
  localparam logic [2:0] T_SEQUENCE = 3'd5;
  localparam logic [2:0] T_REVERSE  = 3'd6;
  localparam logic [2:0] T_BLOB     = 3'd7;

  localparam logic [STATUS_BITS-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TRUNCATED   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_PARTS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PART0     = 3'd1;

  localparam int PI = PART_INDEX_BITS;
  localparam int KB = BYTE_IN_PART_BITS;

  function automatic logic desc_ok(input logic [DESC_BITS-1:0] d);
    logic [PART_SIZE_BITS-1:0] s;
    logic                      r;
    s = d[DESC_BITS-1:5];
    unique case (d[2:0])
      T_LONGLONG: r = (s == PART_SIZE_BITS'(3)) || (s == PART_SIZE_BITS'(8));
      T_NUMBER:   r = (s != '0) && (s <= PART_SIZE_BITS'(MAX_BUFFERED_BYTES));
      T_FLOAT:    r = (s == PART_SIZE_BITS'(4));
      T_DOUBLE:   r = (s == PART_SIZE_BITS'(8));
      T_SEQUENCE: r = 1'b1;
      T_REVERSE:  r = (s <= PART_SIZE_BITS'(MAX_BUFFERED_BYTES));
      T_BLOB:     r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic null_of(input logic [NUM_DESC-1:0] nv, input logic [PI-1:0] idx);
    logic r;
    r = 1'b0;
    if (idx < PI'(NUM_DESC)) r = nv[idx[DESC_SEL_BITS-1:0]];
    return r;
  endfunction

  logic [PI-1:0]          num_parts;
  logic [DESC_BITS-1:0]   part_desc [NUM_DESC];
  logic [PI-1:0]          part_index, part_index_next;
  logic [KB-1:0]          byte_in_part, byte_in_part_next;
  logic                   null_pending, null_pending_next;
  logic [7:0]             value_buffer [MAX_BUFFERED_BYTES];
  logic [7:0]             blob_length_hold [BLOB_LENGTH_BYTES];
  logic [LENGTH_BITS-1:0] length_count, length_count_next;
  logic [STATUS_BITS-1:0] error_status, error_status_next;

  logic [PI-1:0]            lim;
  logic [NUM_DESC-1:0]      ok, nul, skip;
  logic [KB-1:0]            total [NUM_DESC];
  logic                     found;
  logic [DESC_SEL_BITS-1:0] tgt;
  logic [PI-1:0]            tgt_idx;
  logic [DESC_BITS-1:0]     d;
  logic [2:0]               d_type;
  logic [KB-1:0]            kt, k1;
  logic                     npt, fl;
  logic                     accept;
  logic                     buf_we, hold_we;
  logic [STATUS_BITS-1:0]   st;
  logic [7:0]               b;
  logic [DESC_SEL_BITS-1:0] cfg_sel;
  cmd_t                     cmd;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign b         = item.in_byte;
  assign cfg_sel   = DESC_SEL_BITS'(cfg_index - CFG_PART0);

  always_comb begin
    lim = num_parts;
    if (lim > PI'(MAX_PARTS)) lim = PI'(MAX_PARTS);
    if (lim > PI'(NUM_DESC)) lim = PI'(NUM_DESC);
  end

  always_comb begin
    for (int i = 0; i < NUM_DESC; i++) begin
      ok[i]    = desc_ok(part_desc[i]);
      nul[i]   = part_desc[i][3];
      total[i] = KB'(part_desc[i][DESC_BITS-1:5]) +
                 ((part_desc[i][2:0] == T_BLOB) ? KB'(BLOB_LENGTH_BYTES) : KB'(0));
      if (PI'(i) == part_index)
        skip[i] = !null_pending && ok[i] && (byte_in_part >= total[i]);
      else
        skip[i] = !nul[i] && ok[i] && (total[i] == '0);
    end
  end

  // first part at or after the current one that does something with this beat
  always_comb begin
    found = 1'b0;
    tgt   = '0;
    for (int i = 0; i < NUM_DESC; i++) begin
      if (!found && PI'(i) >= part_index && PI'(i) < lim && !skip[i]) begin
        found = 1'b1;
        tgt   = DESC_SEL_BITS'(i);
      end
    end
  end

  always_comb begin
    tgt_idx           = PI'(tgt);
    d                 = part_desc[tgt];
    d_type            = d[2:0];
    fl                = (d_type == T_FLOAT) || (d_type == T_DOUBLE);
    kt                = (tgt_idx == part_index) ? byte_in_part : '0;
    npt               = (tgt_idx == part_index) ? null_pending : nul[tgt];
    k1                = kt + 1'b1;
    part_index_next   = part_index;
    byte_in_part_next = byte_in_part;
    null_pending_next = null_pending;
    error_status_next = error_status;
    buf_we            = 1'b0;
    hold_we           = 1'b0;
    cmd               = '0;
    st                = ST_OK;
    if (error_status == ST_OK && part_index < lim) begin
      if (!found) begin
        part_index_next   = lim;
        byte_in_part_next = '0;
        null_pending_next = null_of(nul, lim);
      end else if (npt) begin
        // null indicator goes out as 0x00
        cmd.count         = COUNT_BITS'(1);
        null_pending_next = 1'b0;
        part_index_next   = tgt_idx;
        byte_in_part_next = kt;
        if (!ok[tgt]) begin
          error_status_next = ST_UNSUPPORTED;
        end else if (total[tgt] == '0) begin
          part_index_next   = tgt_idx + 1'b1;
          byte_in_part_next = '0;
          null_pending_next = null_of(nul, tgt_idx + 1'b1);
        end
      end else if (!ok[tgt]) begin
        error_status_next = ST_UNSUPPORTED;
        part_index_next   = tgt_idx;
        byte_in_part_next = kt;
        null_pending_next = 1'b0;
      end else begin
        unique case (d_type)
          T_SEQUENCE: begin
            cmd.lanes[0] = b;
            cmd.count    = COUNT_BITS'(1);
          end
          T_BLOB: begin
            if (kt < KB'(BLOB_LENGTH_BYTES)) begin
              hold_we = 1'b1;
            end else begin
              cmd.lanes[0] = b;
              cmd.count    = COUNT_BITS'(1);
            end
          end
          default: buf_we = 1'b1;
        endcase
        if (k1 >= total[tgt]) begin
          if (d_type == T_BLOB) begin
            if (kt < KB'(BLOB_LENGTH_BYTES)) begin
              // empty blob: this beat is the second length byte
              cmd.lanes[1] = blob_length_hold[0];
              cmd.lanes[0] = b;
              cmd.start    = LANE_BITS'(1);
              cmd.count    = COUNT_BITS'(2);
            end else begin
              cmd.lanes[2] = b;
              cmd.lanes[1] = blob_length_hold[0];
              cmd.lanes[0] = blob_length_hold[1];
              cmd.start    = LANE_BITS'(2);
              cmd.count    = COUNT_BITS'(3);
            end
          end else if (d_type != T_SEQUENCE) begin
            for (int j = 0; j < MAX_BUFFERED_BYTES; j++)
              cmd.lanes[j] = (LANE_BITS'(j) == kt[LANE_BITS-1:0]) ? b : value_buffer[j];
            cmd.start      = kt[LANE_BITS-1:0];
            cmd.count      = COUNT_BITS'(kt[LANE_BITS-1:0]) + 1'b1;
            // this beat is the most significant byte, so it carries the sign
            cmd.invert     = fl && b[7];
            cmd.flip_first = (fl && !b[7]) || (d_type == T_LONGLONG) ||
                             ((d_type == T_NUMBER) && d[4]);
          end
          part_index_next   = tgt_idx + 1'b1;
          byte_in_part_next = '0;
          null_pending_next = null_of(nul, tgt_idx + 1'b1);
        end else begin
          part_index_next   = tgt_idx;
          byte_in_part_next = k1;
          null_pending_next = 1'b0;
        end
      end
    end
    length_count_next = length_count + LENGTH_BITS'(cmd.count);
    if (item.key_end) begin
      st = error_status_next;
      if (st == ST_OK && part_index_next < lim &&
          (byte_in_part_next != '0 ||
           null_pending_next != null_of(nul, part_index_next)))
        st = ST_TRUNCATED;
      cmd.done   = 1'b1;
      cmd.length = length_count_next;
      cmd.status = st;
    end
  end

  assign q_push = accept && (cmd.count != '0 || item.key_end);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_parts <= '0;
      for (int i = 0; i < NUM_DESC; i++) part_desc[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_NUM_PARTS) begin
        num_parts <= cfg_data[PI-1:0];
      end else if (cfg_index >= CFG_PART0 &&
                   cfg_index <= CFG_INDEX_BITS'(NUM_DESC)) begin
        part_desc[cfg_sel] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_index   <= '0;
      byte_in_part <= '0;
      null_pending <= 1'b0;
      length_count <= '0;
      error_status <= ST_OK;
    end else if (accept) begin
      if (item.key_end) begin
        part_index   <= '0;
        byte_in_part <= '0;
        null_pending <= nul[0];
        length_count <= '0;
        error_status <= ST_OK;
      end else begin
        part_index   <= part_index_next;
        byte_in_part <= byte_in_part_next;
        null_pending <= null_pending_next;
        length_count <= length_count_next;
        error_status <= error_status_next;
      end
    end else if (cfg_valid && cfg_index >= CFG_PART0 &&
                 cfg_index <= CFG_INDEX_BITS'(NUM_DESC)) begin
      // a rewritten descriptor of a part not yet started picks up its null flag
      if (PI'(cfg_sel) == part_index && byte_in_part == '0 &&
          null_pending == part_desc[cfg_sel][3])
        null_pending <= cfg_data[3];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && buf_we) value_buffer[kt[LANE_BITS-1:0]] <= b;
    if (accept && hold_we) blob_length_hold[kt[0]] <= b;
  end

  a_key_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.key_end) |=>
      (part_index == '0 && length_count == '0 && error_status == ST_OK))
    else $error("key state not cleared after key end");

endmodule

// File: rtl/smcke_queue.sv
module smcke_queue #(
  parameter int DEPTH = smcke_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smcke_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output smcke_pkg::cmd_t dout,
  output logic            empty
);
  import smcke_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cmd_t                mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

endmodule

// File: rtl/smcke_back.sv
module smcke_back (
  input  logic               clk,
  input  logic               rst,
  input  smcke_pkg::cmd_t    head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output smcke_pkg::result_t result
);
  import smcke_pkg::*;

  logic [COUNT_BITS-1:0] j;
  logic [LANE_BITS-1:0]  lane;
  logic [7:0]            v;
  logic                  at_done, last, take;

  assign empty = q_empty;
  assign take  = pop && !q_empty;
  assign q_pop = take && last;

  always_comb begin
    lane    = head.start - j[LANE_BITS-1:0];
    v       = head.lanes[lane];
    if (head.invert) v = ~v;
    else if (j == '0 && head.flip_first) v = v ^ 8'h80;
    at_done = (j == head.count);
    last    = at_done || ((j + 1'b1) == head.count && !head.done);
    result          = '0;
    result.run_last = last;
    if (at_done) begin
      result.key_done       = 1'b1;
      result.encoded_length = head.length;
      result.status         = head.status;
    end else begin
      result.out_byte   = v;
      result.byte_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (take) begin
      j <= last ? '0 : j + 1'b1;
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (j < head.count || (j == head.count && head.done)))
    else $error("byte index ran past its command");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import smcke_pkg::*;

  typedef enum logic [2:0] {
    T_UNKNOWN, T_LONGLONG, T_NUMBER, T_FLOAT, T_DOUBLE, T_SEQ, T_REVERSE, T_BLOB
  } part_type_e;

  typedef enum logic [1:0] {ST_OK, ST_UNSUPPORTED, ST_TRUNCATED} key_status_e;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_PARTS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PART0     = 3'd1;

  localparam int MAX_BEATS_PER_ITEM = 9;
  localparam int DIRECTED_ITEMS     = 29;
  localparam int RANDOM_ITEMS       = 400;
  localparam int DRAIN_CYCLES       = 4;
  localparam int PRESSURE_AT        = DIRECTED_ITEMS + 100;
  localparam int PRESSURE_CYCLES    = 200;
  localparam int STALL_LIMIT        = 2000;

  // Predicts the encoded byte stream and holds the beats still to come.
  class encoded_key_board;
    result_t     expected_beats[$];
    result_t     step_beats[$];
    int          source_beats;
    int          errors;

    logic [2:0]           num_parts;
    logic [DESC_BITS-1:0] part_desc[NUM_DESC];

    int                     part_idx;
    int                     byte_idx;
    bit                     null_pend;
    logic [7:0]             num_buf[MAX_BUFFERED_BYTES];
    logic [7:0]             blob_len[BLOB_LENGTH_BYTES];
    logic [LENGTH_BITS-1:0] out_len;
    key_status_e            err_st;

    function new();
      num_parts = '0;
      foreach (part_desc[i]) part_desc[i] = '0;
      foreach (num_buf[i]) num_buf[i] = '0;
      foreach (blob_len[i]) blob_len[i] = '0;
      part_idx = 0;
      byte_idx = 0;
      null_pend = 0;
      out_len = '0;
      err_st = ST_OK;
      source_beats = 0;
      errors = 0;
    endfunction

    function part_type_e ptype(logic [DESC_BITS-1:0] d);
      return part_type_e'(d[2:0]);
    endfunction

    function bit has_null(logic [DESC_BITS-1:0] d);
      return d[3];
    endfunction

    function int psize(logic [DESC_BITS-1:0] d);
      return int'(d[DESC_BITS-1:5]);
    endfunction

    function logic [DESC_BITS-1:0] desc_at(int i);
      return (i < NUM_DESC) ? part_desc[i] : '0;
    endfunction

    function int parts_in_use();
      return (num_parts > MAX_PARTS) ? MAX_PARTS : int'(num_parts);
    endfunction

    function bit supported(logic [DESC_BITS-1:0] d);
      int s;
      s = psize(d);
      case (ptype(d))
        T_LONGLONG: return s == 3 || s == 8;
        T_NUMBER:   return s >= 1 && s <= MAX_BUFFERED_BYTES;
        T_FLOAT:    return s == 4;
        T_DOUBLE:   return s == 8;
        T_SEQ:      return 1;
        T_REVERSE:  return s <= MAX_BUFFERED_BYTES;
        T_BLOB:     return 1;
        default:    return 0;
      endcase
    endfunction

    function int data_len(logic [DESC_BITS-1:0] d);
      return psize(d) + ((ptype(d) == T_BLOB) ? BLOB_LENGTH_BYTES : 0);
    endfunction

    // source bytes a well-formed key needs under the current parts
    function int source_len();
      int n;
      logic [DESC_BITS-1:0] d;
      n = 0;
      for (int i = 0; i < parts_in_use(); i++) begin
        d = part_desc[i];
        if (has_null(d)) n++;
        if (!supported(d)) begin
          if (!has_null(d)) n++;
          break;
        end
        n += data_len(d);
      end
      return n;
    endfunction

    function void configure(logic [CFG_INDEX_BITS-1:0] idx, logic [DESC_BITS-1:0] val);
      logic [DESC_BITS-1:0] old;
      int p;
      if (idx == REG_NUM_PARTS) begin
        num_parts = val[2:0];
      end else if (idx < REG_PART0 + NUM_DESC) begin
        p = int'(idx - REG_PART0);
        old = part_desc[p];
        part_desc[p] = val;
        // an untouched part follows a new null flag
        if (p == part_idx && byte_idx == 0 && null_pend == has_null(old))
          null_pend = has_null(val);
      end
    endfunction

    function void emit(logic [7:0] b, bit valid, bit done, logic [LENGTH_BITS-1:0] len,
                       logic [1:0] st);
      result_t r;
      if (step_beats.size() >= MAX_BEATS_PER_ITEM) return;
      r = '0;
      r.out_byte = b;
      r.byte_valid = valid;
      r.key_done = done;
      r.encoded_length = len;
      r.status = st;
      step_beats.push_back(r);
    endfunction

    function void put_byte(logic [7:0] b);
      emit(b, 1'b1, 1'b0, '0, ST_OK);
      out_len = out_len + 1'b1;
    endfunction

    function void advance();
      part_idx++;
      byte_idx = 0;
      null_pend = has_null(desc_at(part_idx));
    endfunction

    // buffered little-endian value goes out most significant byte first
    function void flush_value(logic [DESC_BITS-1:0] d);
      int s;
      bit neg;
      logic [7:0] v;
      part_type_e t;
      t = ptype(d);
      s = psize(d);
      if (s > MAX_BUFFERED_BYTES) s = MAX_BUFFERED_BYTES;
      neg = (s != 0) ? num_buf[(s - 1) & 7][7] : 1'b0;
      for (int i = 0; i < s; i++) begin
        v = num_buf[(s - 1 - i) & 7];
        if (t == T_FLOAT || t == T_DOUBLE) begin
          if (neg) v = ~v;
          else if (i == 0) v = v ^ 8'h80;
        end else if (i == 0 && (t == T_LONGLONG || (t == T_NUMBER && d[4]))) begin
          v = v ^ 8'h80;
        end
        put_byte(v);
      end
    endfunction

    function void take_data(logic [DESC_BITS-1:0] d, logic [7:0] b);
      part_type_e t;
      t = ptype(d);
      if (t == T_SEQ) begin
        put_byte(b);
      end else if (t == T_BLOB) begin
        if (byte_idx < BLOB_LENGTH_BYTES) blob_len[byte_idx] = b;
        else put_byte(b);
      end else begin
        num_buf[byte_idx & 7] = b;
      end
      byte_idx++;
      if (byte_idx >= data_len(d)) begin
        if (t == T_BLOB) begin
          foreach (blob_len[i]) put_byte(blob_len[i]);
        end else if (t != T_SEQ) begin
          flush_value(d);
        end
        advance();
      end
    endfunction

    function void take_source_byte(logic [7:0] b, logic e);
      int lim;
      logic [DESC_BITS-1:0] d;
      key_status_e st;
      step_beats.delete();
      source_beats++;
      lim = parts_in_use();
      if (err_st == ST_OK) begin
        while (part_idx < lim) begin
          d = desc_at(part_idx);
          if (null_pend) begin
            put_byte(8'h00);
            null_pend = 0;
            if (!supported(d)) err_st = ST_UNSUPPORTED;
            else if (data_len(d) == 0) advance();
            break;
          end
          if (!supported(d)) begin
            err_st = ST_UNSUPPORTED;
            break;
          end
          if (byte_idx >= data_len(d)) begin
            advance();
            continue;
          end
          take_data(d, b);
          break;
        end
      end
      if (e) begin
        st = err_st;
        if (st == ST_OK && part_idx < lim &&
            (byte_idx != 0 || null_pend != has_null(desc_at(part_idx))))
          st = ST_TRUNCATED;
        emit(8'h00, 1'b0, 1'b1, out_len, st);
        part_idx = 0;
        byte_idx = 0;
        null_pend = has_null(part_desc[0]);
        out_len = '0;
        err_st = ST_OK;
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_encoded(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %h", $time, got);
        return;
      end
      want = expected_beats.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("byte_valid", want.byte_valid, got.byte_valid);
      compare("run_last", want.run_last, got.run_last);
      compare("key_done", want.key_done, got.key_done);
      compare("encoded_length", want.encoded_length, got.encoded_length);
      compare("status", want.status, got.status);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [DESC_BITS-1:0]      cfg_data = '0;
  logic                      push = 1'b0;
  logic                      full;
  in_item_t                  item = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  result_t                   result;

  encoded_key_board sb = new();

  sortable_multi_column_key_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DESC_BITS-1:0] make_desc(part_type_e t, bit nul, bit sgn, int sz);
    logic [DESC_BITS-1:0] d;
    d = '0;
    d[2:0] = t;
    d[3] = nul;
    d[4] = sgn;
    d[DESC_BITS-1:5] = sz[PART_SIZE_BITS-1:0];
    return d;
  endfunction

  function automatic logic [DESC_BITS-1:0] random_desc();
    part_type_e t;
    int sz;
    t = ($urandom_range(0, 19) == 0) ? T_UNKNOWN : part_type_e'($urandom_range(1, 7));
    case (t)
      T_LONGLONG: sz = $urandom_range(0, 1) ? 3 : 8;
      T_NUMBER:   sz = $urandom_range(1, 8);
      T_FLOAT:    sz = 4;
      T_DOUBLE:   sz = 8;
      T_REVERSE:  sz = $urandom_range(0, 8);
      default:    sz = $urandom_range(0, 6);
    endcase
    // now and then any size at all, mostly unsupported or very long
    if ($urandom_range(0, 19) == 0) sz = $urandom_range(0, 4095);
    return make_desc(t, $urandom_range(0, 1), $urandom_range(0, 1), sz);
  endfunction

  function automatic logic [DESC_BITS-1:0] random_num_parts();
    logic [DESC_BITS-1:0] v;
    int r;
    v = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) v[2:0] = 3'd0;
    else if (r < 85) v[2:0] = $urandom_range(1, 4);
    else v[2:0] = $urandom_range(5, 7);
    return v;
  endfunction

  function automatic logic [7:0] random_byte();
    logic [7:0] corners[4];
    corners = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 3)];
    return $urandom_range(0, 255);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [DESC_BITS-1:0] val, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, val);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_parts(logic [DESC_BITS-1:0] nparts, logic [DESC_BITS-1:0] d[NUM_DESC]);
    write_reg(REG_NUM_PARTS, nparts, 1'b0);
    for (int i = 0; i < NUM_DESC; i++) write_reg(REG_PART0 + i, d[i], i == NUM_DESC - 1);
  endtask

  // lets the block run dry so registers can be touched
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic e, bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{in_byte: b, key_end: e};
    do @(posedge clk); while (full);
    sb.take_source_byte(b, e);
  endtask

  task automatic send_key(logic [7:0] src[$], bit steady, int rewrite_at);
    logic [CFG_INDEX_BITS-1:0] idx;
    for (int i = 0; i < src.size(); i++) begin
      if (i == rewrite_at) begin
        // descriptor change in the middle of a key
        wait_idle();
        idx = $urandom_range(0, NUM_DESC);
        write_reg(idx, (idx == REG_NUM_PARTS) ? random_num_parts() : random_desc(), 1'b1);
      end
      send_byte(src[i], i == src.size() - 1, steady);
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : drain_results
    int stall;
    int gap;
    int rx_cycle;
    bit pressed;
    stall = 0;
    rx_cycle = 0;
    pressed = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!rst && pop && !empty) sb.check_encoded(result);
      if (!pressed && sb.source_beats >= PRESSURE_AT) begin
        pressed = 1;
        stall = PRESSURE_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (rx_cycle % 300 < 60) begin
        pop <= 1'b1;
      end else begin
        gap = pick_gap();
        pop <= (gap == 0);
        stall = (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [DESC_BITS-1:0] d[NUM_DESC];
    logic [7:0]           key[$];
    int                   len;
    int                   n;
    int                   r;
    bit                   steady;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // write to an index past the last part: ignored
    write_reg(REG_PART0 + NUM_DESC, '1, 1'b0);

    // signed 8-byte number, blob with null and empty data, 3-byte long long,
    // one trailing byte after the last part
    d = '{make_desc(T_NUMBER, 0, 1, 8), make_desc(T_BLOB, 1, 0, 0),
          make_desc(T_LONGLONG, 0, 0, 3), make_desc(T_FLOAT, 0, 0, 4)};
    program_parts(3, d);
    key = '{8'h00, 8'hFF, 8'h01, 8'h7F, 8'h80, 8'h55, 8'hAA, 8'h80,
            8'h5A, 8'h34, 8'h12, 8'h01, 8'h02, 8'h83, 8'hFF};
    send_key(key, 0, -1);

    // too many parts; reverse, sequence with null, unknown type
    wait_idle();
    d = '{make_desc(T_REVERSE, 0, 0, 2), make_desc(T_SEQ, 1, 0, 1), '0,
          make_desc(T_DOUBLE, 1, 1, 8)};
    program_parts('1, d);
    key = '{8'h11, 8'h22, 8'h00, 8'hC3, 8'h44, 8'h66};
    send_key(key, 0, -1);

    // zero-size reverse part, then a double cut short
    wait_idle();
    d = '{make_desc(T_REVERSE, 0, 0, 0), make_desc(T_DOUBLE, 0, 0, 8),
          make_desc(T_SEQ, 0, 0, 1), make_desc(T_SEQ, 0, 0, 1)};
    program_parts(2, d);
    key = '{8'h01, 8'h02, 8'h03};
    send_key(key, 0, -1);

    // widest descriptor: blob with null and maximum size, truncated
    wait_idle();
    d = '{'1, '0, '0, '0};
    program_parts(1, d);
    key = '{8'hAB, 8'hCD, 8'hEF, 8'h99};
    send_key(key, 0, -1);

    // no parts at all
    wait_idle();
    program_parts(0, d);
    key = '{8'h77};
    send_key(key, 0, -1);

    while (sb.source_beats < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      wait_idle();
      foreach (d[i]) d[i] = random_desc();
      program_parts(random_num_parts(), d);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        len = sb.source_len();
        r = $urandom_range(0, 99);
        if (len > 48) n = $urandom_range(1, 12);
        else if (r < 70) n = len;
        else if (r < 82) n = len + $urandom_range(1, 3);
        else if (r < 95) n = (len > 1) ? $urandom_range(1, len - 1) : len;
        else n = $urandom_range(1, 8);
        if (n < 1) n = 1;
        key.delete();
        repeat (n) key.push_back(random_byte());
        send_key(key, steady, ($urandom_range(0, 11) == 0 && n >= 4) ? n / 2 : -1);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
